/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh - shared assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge out of reset.
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds at a rising clock edge out of reset.
`define CFT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* sv/cft_pkg.sv */
// ----------------------------------------------------------------------------
// cft_pkg - shared types and constants
// Opcodes, byte classes, state encodings and the triple record.
// ----------------------------------------------------------------------------
package cft_pkg;

  // Default sizing
  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned COUNT_BITS_DEF    = 32;

  // Fixed field widths
  localparam int unsigned CODE_BITS  = 24;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned INUSE_BITS = 11;
  localparam int unsigned OCC_BITS   = 32;

  // Opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Byte classes
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] LEAD_LO       = 8'hE0;
  localparam logic [7:0] LEAD_HI       = 8'hEF;
  localparam logic [7:0] CONT_LO       = 8'h80;
  localparam logic [7:0] CONT_HI       = 8'hBF;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ
  } state_e;

  // Completed, qualifying triple from the byte framer
  typedef struct packed {
    logic                   hit;
    logic [CODE_BITS-1:0]   code;
  } triple_t;

endpackage

/* sv/cft_table_mem.sv */
// ----------------------------------------------------------------------------
// cft_table_mem - entry storage
// Single-clock RAM, one write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cft_table_mem #(
  parameter int unsigned DEPTH     = cft_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS = 10,
  parameter int unsigned DATA_BITS = 56
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output logic [DATA_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic [DATA_BITS-1:0] wr_data_i
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/cft_byte_framer.sv */
// ----------------------------------------------------------------------------
// cft_byte_framer - byte to triple grouping
// Drops LF/CR, groups bytes into triples and flags three-byte sequences.
// ----------------------------------------------------------------------------
module cft_byte_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       byte_i,
  output cft_pkg::triple_t triple_o
);

  cft_pkg::phase_e phase_q, phase_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic            take;

  function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  assign take = push_i && (byte_i != cft_pkg::BYTE_LF) && (byte_i != cft_pkg::BYTE_CR);

  // Next phase and held bytes
  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    if (take) begin
      unique case (phase_q)
        cft_pkg::PH_FIRST: begin
          first_d = byte_i;
          phase_d = cft_pkg::PH_SECOND;
        end
        cft_pkg::PH_SECOND: begin
          second_d = byte_i;
          phase_d  = cft_pkg::PH_THIRD;
        end
        default: begin
          phase_d = cft_pkg::PH_FIRST;
        end
      endcase
    end
  end

  // Triple output
  always_comb begin
    triple_o.code = {first_q, second_q, byte_i};
    triple_o.hit  = take && (phase_q == cft_pkg::PH_THIRD)
                    && in_range(first_q, cft_pkg::LEAD_LO, cft_pkg::LEAD_HI)
                    && in_range(second_q, cft_pkg::CONT_LO, cft_pkg::CONT_HI)
                    && in_range(byte_i, cft_pkg::CONT_LO, cft_pkg::CONT_HI);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cft_pkg::PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

/* sv/character_frequency_table.sv */
// ----------------------------------------------------------------------------
// character_frequency_table - histogram of three-byte UTF-8 sequences
// Push transaction: the byte closing a counted triple adds a table
//   search over the entries in use, one RAM read per cycle.
// Read transaction: RAM read on accept, result loaded once output is free.
// Reset: control and entry count clear at once; no RAM clearing pass.
// ----------------------------------------------------------------------------
module character_frequency_table #(
  parameter int unsigned TABLE_ENTRIES = cft_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS    = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [7:0]                       data_byte_i,
  input  logic [cft_pkg::INDEX_BITS-1:0]   entry_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cft_pkg::CODE_BITS-1:0]    char_code_o,
  output logic [cft_pkg::OCC_BITS-1:0]     occurrence_count_o,
  output logic [cft_pkg::INUSE_BITS-1:0]   entries_in_use_o,
  output logic                             entry_valid_o
);

  // Sizing: address bits, width of the fill count, widened index compare
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IW = (CW > cft_pkg::INDEX_BITS) ? CW : cft_pkg::INDEX_BITS;
  localparam int unsigned DW = cft_pkg::CODE_BITS + COUNT_BITS;

  // Controller state
  cft_pkg::state_e         state_q, state_d;
  logic [cft_pkg::CODE_BITS-1:0] code_q, code_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic [CW-1:0]           used_q, used_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic                    rd_valid_q, rd_valid_d;

  // Output register: holds a finished result while the consumer stalls
  logic                            out_valid_q;
  logic [cft_pkg::CODE_BITS-1:0]   char_q;
  logic [cft_pkg::OCC_BITS-1:0]    occ_q;
  logic [cft_pkg::INUSE_BITS-1:0]  inuse_q;
  logic                            ev_q;

  // Handshake decode
  logic in_acc, push_acc, read_acc;
  assign in_ready_o = (state_q == cft_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign push_acc   = in_acc && (opcode_i == cft_pkg::OP_PUSH);
  assign read_acc   = in_acc && (opcode_i == cft_pkg::OP_READ);

  // Triples come from the framer
  cft_pkg::triple_t triple;

  cft_byte_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_acc),
    .byte_i   (data_byte_i),
    .triple_o (triple)
  );

  // RAM port
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;

  cft_table_mem #(
    .DEPTH     (TABLE_ENTRIES),
    .ADDR_BITS (AW),
    .DATA_BITS (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Entry fields of the word from the last RAM read
  logic [cft_pkg::CODE_BITS-1:0] rd_code;
  logic [COUNT_BITS-1:0]         rd_count, inc_count;
  logic [63:0]                   rd_count_ext;
  assign rd_code      = rd_data[DW-1:COUNT_BITS];
  assign rd_count     = rd_data[COUNT_BITS-1:0];
  assign rd_count_ext = 64'(rd_count);
  // Saturate at all ones
  assign inc_count    = (rd_count == '1) ? rd_count : rd_count + 1'b1;

  // Search status: a pending read matched, or every entry has been compared
  logic search_hit, scan_more, room, out_free;
  assign search_hit = pend_q && (rd_code == code_q);
  assign scan_more  = (scan_q < used_q);
  assign room       = (used_q < CW'(TABLE_ENTRIES));
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cft_pkg::ST_IDLE: begin
        if (read_acc) begin
          state_d = cft_pkg::ST_READ;
        end else if (triple.hit) begin
          state_d = cft_pkg::ST_SEARCH;
        end
      end
      cft_pkg::ST_SEARCH: begin
        if (search_hit || !scan_more) begin
          state_d = cft_pkg::ST_IDLE;
        end
      end
      cft_pkg::ST_READ: begin
        if (out_free) begin
          state_d = cft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cft_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control: one RAM read per search cycle, compare the word read
  // in the previous cycle, write back on a hit, else append if not full.
  logic load_out;
  always_comb begin
    code_d      = code_q;
    scan_d      = scan_q;
    used_d      = used_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    rd_valid_d  = rd_valid_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_addr_q;
    wr_data     = {code_q, inc_count};
    load_out    = 1'b0;
    unique case (state_q)
      cft_pkg::ST_IDLE: begin
        if (read_acc) begin
          // Issue the read; note whether the index is in use
          rd_en      = 1'b1;
          rd_addr    = AW'(entry_index_i);
          rd_valid_d = (IW'(entry_index_i) < IW'(used_q));
        end else if (triple.hit) begin
          // Start the search from entry zero
          code_d = triple.code;
          scan_d = '0;
          pend_d = 1'b0;
        end
      end
      cft_pkg::ST_SEARCH: begin
        if (search_hit) begin
          wr_en = 1'b1;
        end else if (scan_more) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = scan_q[AW-1:0];
          scan_d      = scan_q + 1'b1;
        end else if (room) begin
          // Append a new entry with a count of one
          wr_en   = 1'b1;
          wr_addr = used_q[AW-1:0];
          wr_data = {code_q, COUNT_BITS'(1)};
          used_d  = used_q + 1'b1;
        end
      end
      cft_pkg::ST_READ: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cft_pkg::ST_IDLE;
      used_q     <= '0;
      pend_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      pend_q     <= pend_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Indexes not in use report zeros
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      char_q  <= rd_valid_q ? rd_code : '0;
      occ_q   <= rd_valid_q ? rd_count_ext[cft_pkg::OCC_BITS-1:0] : '0;
      inuse_q <= cft_pkg::INUSE_BITS'(used_q);
      ev_q    <= rd_valid_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign char_code_o        = char_q;
  assign occurrence_count_o = occ_q;
  assign entries_in_use_o   = inuse_q;
  assign entry_valid_o      = ev_q;

endmodule

/* sv/cft_checker.sv */
// ----------------------------------------------------------------------------
// cft_checker - port-level checks
// Watches the result channel of character_frequency_table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cft_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [cft_pkg::CODE_BITS-1:0]    char_code_o,
  input logic [cft_pkg::OCC_BITS-1:0]     occurrence_count_o,
  input logic [cft_pkg::INUSE_BITS-1:0]   entries_in_use_o,
  input logic                             entry_valid_o
);

  // A stalled result holds
  `CFT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o) && $stable(occurrence_count_o) && $stable(entries_in_use_o) && $stable(entry_valid_o), "stalled result changed")

  // Unused entries read as zero
  `CFT_ASSERT_NEVER(a_invalid_zero, out_valid_o && !entry_valid_o && (char_code_o != '0 || occurrence_count_o != '0), "unused entry returned data")

  // Stored codes are always three-byte sequences
  `CFT_ASSERT(a_code_shape, out_valid_o && entry_valid_o |-> char_code_o[23:20] == 4'hE && char_code_o[15:14] == 2'b10 && char_code_o[7:6] == 2'b10, "stored code is malformed")

endmodule

bind character_frequency_table cft_checker u_cft_checker (.*);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - character_frequency_table verification
// Random and directed byte streams and table reads. A local histogram
// predicts every read result; results are checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  localparam int unsigned TRIPLE_POOL_SIZE = 48;
  localparam int unsigned RANDOM_ITEMS     = 260;
  // Distinct triples that grow the table well past the pool
  localparam int unsigned FILL_TRIPLES     = 40;
  localparam int unsigned AFTER_FILL_ITEMS = 20;
  // Well above the length of a full-table search
  localparam int unsigned STALL_LIMIT      = 20000;
  localparam int unsigned DRAIN_CYCLES     = 1100;
  localparam longint unsigned COUNT_MAX =
    (COUNT_BITS_DEF >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << COUNT_BITS_DEF) - 64'd1);

  typedef struct packed {
    logic                  opcode;
    logic [7:0]            data_byte;
    logic [INDEX_BITS-1:0] entry_index;
  } text_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  char_code;
    logic [OCC_BITS-1:0]   occurrence_count;
    logic [INUSE_BITS-1:0] entries_in_use;
    logic                  entry_valid;
  } lookup_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i      = OP_PUSH;
  logic [7:0]            data_byte_i   = '0;
  logic [INDEX_BITS-1:0] entry_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [CODE_BITS-1:0]  char_code_o;
  logic [OCC_BITS-1:0]   occurrence_count_o;
  logic [INUSE_BITS-1:0] entries_in_use_o;
  logic                  entry_valid_o;

  character_frequency_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .data_byte_i        (data_byte_i),
    .entry_index_i      (entry_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .char_code_o        (char_code_o),
    .occurrence_count_o (occurrence_count_o),
    .entries_in_use_o   (entries_in_use_o),
    .entry_valid_o      (entry_valid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Histogram predictor: byte framing, triple qualification and table update
  // --------------------------------------------------------------------------
  phase_e               text_phase  = PH_FIRST;
  logic [7:0]           first_byte  = '0;
  logic [7:0]           second_byte = '0;
  logic [CODE_BITS-1:0] tally_code [TABLE_ENTRIES_DEF];
  longint unsigned      tally_count [TABLE_ENTRIES_DEF];
  int unsigned          tally_used  = 0;

  function automatic bit is_cont(logic [7:0] b);
    return b >= CONT_LO && b <= CONT_HI;
  endfunction

  function automatic void histogram_push(logic [7:0] b);
    logic [CODE_BITS-1:0] code;
    bit                   found;
    // Line breaks vanish from the stream without touching the framing
    if (b == BYTE_LF || b == BYTE_CR) return;
    case (text_phase)
      PH_FIRST: begin
        first_byte = b;
        text_phase = PH_SECOND;
      end
      PH_SECOND: begin
        second_byte = b;
        text_phase  = PH_THIRD;
      end
      default: begin
        text_phase = PH_FIRST;
        if (first_byte >= LEAD_LO && first_byte <= LEAD_HI && is_cont(second_byte) &&
            is_cont(b)) begin
          code  = {first_byte, second_byte, b};
          found = 1'b0;
          for (int i = 0; i < tally_used; i++) begin
            if (!found && tally_code[i] == code) begin
              found = 1'b1;
              // Hold a count that has reached its ceiling
              if (tally_count[i] != COUNT_MAX) tally_count[i]++;
            end
          end
          // Drop a new triple once the table is full
          if (!found && tally_used < TABLE_ENTRIES_DEF) begin
            tally_code[tally_used]  = code;
            tally_count[tally_used] = 1;
            tally_used++;
          end
        end
      end
    endcase
  endfunction

  function automatic lookup_t histogram_read(logic [INDEX_BITS-1:0] idx);
    lookup_t r;
    r.entries_in_use   = INUSE_BITS'(tally_used);
    r.entry_valid      = (idx < tally_used);
    r.char_code        = r.entry_valid ? tally_code[idx] : '0;
    r.occurrence_count = r.entry_valid ? OCC_BITS'(tally_count[idx]) : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders: keep the generator's own view of the byte framing so
  // that well-formed triples can be lined up on a triple boundary.
  // --------------------------------------------------------------------------
  text_item_t           pending_items[$];
  lookup_t              awaited_lookups[$];
  int unsigned          mismatches = 0;
  int unsigned          stim_items = 0;
  int unsigned          gen_phase  = 0;
  logic [CODE_BITS-1:0] triple_pool [TRIPLE_POOL_SIZE];

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF || b == BYTE_CR);
    return b;
  endfunction

  function automatic logic [CODE_BITS-1:0] fill_code(int unsigned k);
    return {LEAD_LO | 8'(k >> 12), CONT_LO | 8'((k >> 6) & 63), CONT_LO | 8'(k & 63)};
  endfunction

  task automatic queue_push(logic [7:0] b);
    text_item_t item;
    item.opcode      = OP_PUSH;
    item.data_byte   = b;
    item.entry_index = INDEX_BITS'($urandom_range(0, 1023));
    pending_items.push_back(item);
    if (b != BYTE_LF && b != BYTE_CR) begin
      gen_phase = (gen_phase + 1) % 3;
      stim_items++;
    end
  endtask

  task automatic queue_read(int unsigned idx);
    text_item_t item;
    item.opcode      = OP_READ;
    item.data_byte   = 8'($urandom_range(0, 255));
    item.entry_index = INDEX_BITS'(idx);
    pending_items.push_back(item);
    stim_items++;
  endtask

  // Realign on a triple boundary, then send the three bytes with the odd
  // line break mixed in.
  task automatic queue_triple(logic [CODE_BITS-1:0] code);
    while (gen_phase != 0) queue_push(plain_byte());
    for (int i = 2; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) queue_push($urandom_range(0, 1) ? BYTE_LF : BYTE_CR);
      queue_push(code[8*i +: 8]);
    end
  endtask

  initial begin : stimulus
    int unsigned          mark;
    int unsigned          sel;
    logic [CODE_BITS-1:0] code;

    for (int i = 0; i < TRIPLE_POOL_SIZE; i++)
      triple_pool[i] = {LEAD_LO + 8'($urandom_range(0, 15)), CONT_LO + 8'($urandom_range(0, 63)),
                        CONT_LO + 8'($urandom_range(0, 63))};

    // Directed: read of an empty table, class boundaries, line breaks inside
    // a triple, a repeated triple, each byte position out of class.
    queue_read(0);
    queue_triple({LEAD_LO, CONT_LO, CONT_LO});
    queue_push(LEAD_HI);
    queue_push(BYTE_LF);
    queue_push(CONT_HI);
    queue_push(BYTE_CR);
    queue_push(CONT_HI);
    queue_triple({LEAD_LO, CONT_LO, CONT_LO});
    queue_triple({LEAD_LO - 8'd1, CONT_LO, CONT_LO});
    queue_triple({LEAD_HI + 8'd1, CONT_HI, CONT_HI});
    queue_triple({LEAD_LO, CONT_LO - 8'd1, CONT_LO});
    queue_triple({LEAD_LO, CONT_LO, CONT_HI + 8'd1});
    queue_push(8'h00);
    queue_push(8'hFF);
    queue_push(LEAD_LO);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_read(TABLE_ENTRIES_DEF - 1);

    // Random: mostly well-formed triples from a small pool so that counts
    // climb, with broken triples, loose bytes and reads mixed in.
    mark = stim_items;
    while (stim_items - mark < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        queue_triple(triple_pool[$urandom_range(0, TRIPLE_POOL_SIZE - 1)]);
      end else if (sel < 75) begin
        queue_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63));
      end else if (sel < 87) begin
        code = triple_pool[$urandom_range(0, TRIPLE_POOL_SIZE - 1)];
        code[8*$urandom_range(0, 2) +: 8] = plain_byte();
        queue_triple(code);
      end else begin
        queue_push(8'($urandom_range(0, 255)));
      end
    end

    // Grow the table with a run of distinct triples
    for (int unsigned k = 0; k < FILL_TRIPLES; k++) begin
      queue_triple(fill_code(k));
      if (k % 8 == 7) queue_read($urandom_range(0, 1023));
    end

    // Repeats of the run still count, further new triples are appended
    for (int unsigned j = 0; j < AFTER_FILL_ITEMS; j++) begin
      case ($urandom_range(0, 2))
        0:       queue_triple(fill_code($urandom_range(0, FILL_TRIPLES - 1)));
        1:       queue_triple(fill_code(2048 + j));
        default: queue_read($urandom_range(0, 1023));
      endcase
    end
    queue_read(TABLE_ENTRIES_DEF - 1);
    queue_read(0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to be taken and every result to arrive
    while (pending_items.size() != 0 || in_valid_i || awaited_lookups.size() != 0)
      @(posedge clk_i);
    // Let a trailing table search finish; any stray result is flagged
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present queued items in bursts of random length, with random
  // gaps in between. Hold valid and payload until the transaction is taken.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    text_item_t item;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= OP_PUSH;
      data_byte_i   <= '0;
      entry_index_i <= '0;
      burst_left    = 1;
      gap_left      = 0;
    end else begin
      // Advance the predictor on each accepted transaction, in order
      if (in_valid_i && in_ready_o) begin
        if (opcode_i == OP_READ) begin
          awaited_lookups.push_back(histogram_read(entry_index_i));
        end else begin
          histogram_push(data_byte_i);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item = pending_items.pop_front();
          opcode_i      <= item.opcode;
          data_byte_i   <= item.data_byte;
          entry_index_i <= item.entry_index;
          in_valid_i    <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // Half the bursts run straight into the next one
            case ($urandom_range(0, 7))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6:    gap_left = $urandom_range(1, 4);
              default:    gap_left = $urandom_range(8, 30);
            endcase
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction. Drive
  // ready from a rotating stall pattern, redrawn when pattern_age wraps.
  // --------------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_age   = 0;

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : lookup_monitor
    lookup_t want;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      ready_pattern = 16'hFFFF;
      pattern_age   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_lookups.size() == 0) begin
          mismatches++;
          $display("%0t ns: no result expected, got char_code 0x%0h entries_in_use %0d",
                   $time, char_code_o, entries_in_use_o);
        end else begin
          want = awaited_lookups.pop_front();
          check_field("char_code", 32'(want.char_code), 32'(char_code_o));
          check_field("occurrence_count", want.occurrence_count, occurrence_count_o);
          check_field("entries_in_use", 32'(want.entries_in_use), 32'(entries_in_use_o));
          check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid_o));
        end
      end
      pattern_age++;
      if (pattern_age == 64) begin
        pattern_age = 0;
        // Never draw an all-stall pattern
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'h5555;
          2:       ready_pattern = 16'h00FF;
          default: ready_pattern = 16'($urandom()) | 16'h0001;
        endcase
      end else begin
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      end
      out_ready_i <= ready_pattern[15];
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule

/* files.f */
+incdir+sv
sv/cft_pkg.sv
sv/cft_table_mem.sv
sv/cft_byte_framer.sv
sv/character_frequency_table.sv
sv/cft_checker.sv
bench/testbench.sv
